// ===== design/rqd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_pkg
// Shared types and constants of the queue drop decision core.
// ----------------------------------------------------------------------------
package rqd_pkg;

    localparam logic [1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [1:0] MODE_EMPTY   = 2'd1;
    localparam logic [1:0] MODE_TABLE   = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_PDROP  = 2'd1;
    localparam logic [1:0] VERDICT_FDROP  = 2'd2;

    localparam logic [2:0] REG_MIN_TH   = 3'd0;
    localparam logic [2:0] REG_MAX_TH   = 3'd1;
    localparam logic [2:0] REG_WEIGHT   = 3'd2;
    localparam logic [2:0] REG_PROB_LOG = 3'd3;
    localparam logic [2:0] REG_CELL_LOG = 3'd4;
    localparam logic [2:0] REG_MAX_PROB = 3'd5;

    localparam logic [63:0] MAX_MARGIN  = 64'd2000;
    localparam logic [63:0] PEN_LIMIT   = 64'd15;
    localparam logic [7:0]  IDLE_CELLS  = 8'd255;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EWMA,
        ST_PEN_START,
        ST_PEN_WAIT,
        ST_MOD,
        ST_RD,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_LIN,
        ST_PEN1,
        ST_PEN2,
        ST_DECIDE,
        ST_PROB,
        ST_PROB2,
        ST_DRAW,
        ST_DRAW1,
        ST_DRAW2,
        ST_DRAW3,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic        short_op;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== design/rqd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_div
// Restoring divider, one quotient bit per cycle, 64 or 32 dividend bits.
// ----------------------------------------------------------------------------
module rqd_div
    import rqd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [63:0] quo_reg,  quo_next;
    logic [32:0] rem_reg,  rem_next;
    logic [31:0] dvs_reg,  dvs_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[63]};
        if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            rem_next  = 33'd0;
            dvs_next  = req.divisor;
            busy_next = 1'b1;
            if (req.short_op)
            begin
                quo_next = {req.dividend[31:0], 32'd0};
                cnt_next = 7'd32;
            end
            else
            begin
                quo_next = req.dividend;
                cnt_next = 7'd64;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// ===== design/red_queue_drop_decision_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// red_queue_drop_decision_core
// Random early detection drop decision with idle-time decay of the average.
// ----------------------------------------------------------------------------
// One item is taken at a time and every item gives one result transfer.
// Drawing a new random target uses two 32-bit divisions in the shared
// bit-serial divider. The first arrival after idle adds a 64-bit division
// for the backlog penalty when the backlog is nonzero, a reduction of the
// table index by repeated subtraction, and, when the table entry is zero,
// the two 32x32 partial products of the linear decay. After reset the
// decay table is cleared entry by entry before the first item is taken;
// configuration writes are taken at any time.
module red_queue_drop_decision_core
    import rqd_pkg::*;
#(
    parameter int DECAY_TABLE_DEPTH = 256
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // backlog, now_us, random_word, table_index, table_value
    input  wire logic [111:0] s_tdata,
    // mode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // verdict, avg_queue, zero fill
    output logic      [71:0]  m_tdata
);

    localparam int AW = (DECAY_TABLE_DEPTH > 1) ? $clog2(DECAY_TABLE_DEPTH) : 1;

    logic [23:0] min_reg, max_reg;
    logic [4:0]  wl_reg, cell_reg;
    logic [5:0]  plog_reg;
    logic [31:0] mprob_reg;

    state_t      state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;
    logic [63:0] avg_reg, avg_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] tgt_reg, tgt_next;
    logic        idle_reg, idle_next;
    logic [31:0] istart_reg, istart_next;
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] blog_reg, blog_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] rnd_reg, rnd_next;
    logic [7:0]  mod_reg, mod_next;
    logic [7:0]  tval_reg, tval_next;
    logic [31:0] itime_reg, itime_next;
    logic [63:0] pen_reg, pen_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] plo_reg, plo_next;
    logic [95:0] prod_reg, prod_next;
    logic [31:0] per_reg, per_next;
    logic [1:0]  verd_reg, verd_next;
    logic        ov_reg, ov_next;
    logic [65:0] od_reg, od_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p_reg;

    logic [7:0]  mem [DECAY_TABLE_DEPTH];
    logic [7:0]  tbl_q;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]  mem_wdata;

    div_req_t    dreq;
    div_rsp_t    drsp;

    logic        cfg_we;
    logic        accept;
    logic [63:0] qmin, qmax, lowered, keep, half, pen_q, term, shq;
    logic [64:0] esum;
    logic [95:0] lsh;
    logic [39:0] cap;
    logic [31:0] idle32, idle_c, base, cnt_inc, maxp;
    logic [23:0] gap;

    rqd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= 24'd0;
            max_reg   <= 24'd0;
            wl_reg    <= 5'd9;
            plog_reg  <= 6'd0;
            cell_reg  <= 5'd0;
            mprob_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_MIN_TH:   min_reg   <= pwdata[23:0];
                REG_MAX_TH:   max_reg   <= pwdata[23:0];
                REG_WEIGHT:   wl_reg    <= pwdata[4:0];
                REG_PROB_LOG: plog_reg  <= pwdata[5:0];
                REG_CELL_LOG: cell_reg  <= pwdata[4:0];
                REG_MAX_PROB: mprob_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MIN_TH:   prdata = {8'd0, min_reg};
            REG_MAX_TH:   prdata = {8'd0, max_reg};
            REG_WEIGHT:   prdata = {27'd0, wl_reg};
            REG_PROB_LOG: prdata = {26'd0, plog_reg};
            REG_CELL_LOG: prdata = {27'd0, cell_reg};
            REG_MAX_PROB: prdata = mprob_reg;
            default:      prdata = 32'd0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, od_reg};

    // Shared 32x32 multiplier with a registered product.
    always_ff @(posedge clk)
    begin
        mul_p_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        tbl_q <= mem[AW'(mod_reg)];
    end

    always_comb
    begin
        qmin    = 64'(min_reg) << wl_reg;
        qmax    = 64'(max_reg) << wl_reg;
        lowered = (qmax > MAX_MARGIN) ? qmax - MAX_MARGIN : 64'd0;
        keep    = avg_reg - (avg_reg >> wl_reg);
        esum    = {1'b0, keep} + {33'd0, blog_reg};
        half    = avg_reg >> 1;
        cap     = {32'd0, IDLE_CELLS} << cell_reg;
        idle32  = now_reg - istart_reg;
        idle_c  = ({8'd0, idle32} > cap) ? cap[31:0] : idle32;
        // Ten times the quotient, as eight times plus two times.
        pen_q   = (drsp.quotient <= PEN_LIMIT) ? 64'd0
                : (drsp.quotient << 3) + (drsp.quotient << 1);
        shq     = (tbl_q >= 8'd64) ? 64'd0 : (avg_reg >> tbl_q[5:0]);
        lsh     = prod_reg >> cell_reg;
        term    = lsh[63:0];
        gap     = (max_reg > min_reg) ? max_reg - min_reg : 24'd1;
        base    = (plog_reg < 6'd32) ? (32'hFFFF_FFFF >> plog_reg[4:0]) : 32'hFFFF_FFFF;
        maxp    = (mprob_reg != 32'd0) ? mprob_reg : mul_p_reg[31:0];
        cnt_inc = cnt_reg + 32'd1;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        avg_next    = avg_reg;
        cnt_next    = cnt_reg;
        tgt_next    = tgt_reg;
        idle_next   = idle_reg;
        istart_next = istart_reg;
        mode_next   = mode_reg;
        blog_next   = blog_reg;
        now_next    = now_reg;
        rnd_next    = rnd_reg;
        mod_next    = mod_reg;
        tval_next   = tval_reg;
        itime_next  = itime_reg;
        pen_next    = pen_reg;
        q_next      = q_reg;
        a_next      = a_reg;
        plo_next    = plo_reg;
        prod_next   = prod_reg;
        per_next    = per_reg;
        verd_next   = verd_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        mul_a       = 32'd0;
        mul_b       = 32'd0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(mod_reg);
        mem_wdata   = tval_reg;
        dreq        = '0;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                mem_wdata = 8'd0;
                clr_next  = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(DECAY_TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = s_tuser;
                    blog_next = s_tdata[31:0];
                    now_next  = s_tdata[63:32];
                    rnd_next  = s_tdata[95:64];
                    mod_next  = s_tdata[103:96];
                    tval_next = s_tdata[111:104];
                    verd_next = VERDICT_ACCEPT;
                    case (s_tuser)
                        MODE_ARRIVAL: state_next = idle_reg ? ST_PEN_START : ST_EWMA;
                        MODE_EMPTY:
                        begin
                            if (!idle_reg)
                            begin
                                idle_next   = 1'b1;
                                istart_next = s_tdata[63:32];
                            end
                            state_next = ST_OUT;
                        end
                        MODE_TABLE:   state_next = ST_MOD;
                        default:
                        begin
                            idle_next  = 1'b0;
                            avg_next   = 64'd0;
                            cnt_next   = 32'hFFFF_FFFF;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_EWMA:
            begin
                avg_next   = esum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : esum[63:0];
                idle_next  = 1'b0;
                state_next = ST_DECIDE;
            end
            ST_PEN_START:
            begin
                itime_next = idle_c;
                mod_next   = 8'(idle_c >> cell_reg);
                if (blog_reg == 32'd0)
                begin
                    pen_next   = 64'd0;
                    state_next = ST_MOD;
                end
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.short_op = 1'b0;
                    dreq.dividend = qmin;
                    dreq.divisor  = blog_reg;
                    state_next    = ST_PEN_WAIT;
                end
            end
            ST_PEN_WAIT:
            begin
                if (drsp.done)
                begin
                    pen_next   = pen_q;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (32'(mod_reg) >= 32'(DECAY_TABLE_DEPTH))
                begin
                    mod_next = mod_reg - 8'(DECAY_TABLE_DEPTH);
                end
                else if (mode_reg == MODE_TABLE)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (tbl_q != 8'd0)
                begin
                    q_next     = shq;
                    state_next = ST_PEN1;
                end
                else
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                mul_a      = avg_reg[31:0];
                mul_b      = itime_reg;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                mul_a      = avg_reg[63:32];
                mul_b      = itime_reg;
                plo_next   = mul_p_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = {mul_p_reg, 32'd0} + {32'd0, plo_reg};
                state_next = ST_LIN;
            end
            ST_LIN:
            begin
                q_next     = ((lsh[95:64] == 32'd0) && (term < half)) ? avg_reg - term : half;
                state_next = ST_PEN1;
            end
            ST_PEN1:
            begin
                q_next     = (q_reg > pen_reg) ? q_reg - pen_reg : 64'd0;
                state_next = ST_PEN2;
            end
            ST_PEN2:
            begin
                avg_next   = (q_reg > pen_reg) ? q_reg - pen_reg : q_reg;
                idle_next  = 1'b0;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (avg_reg < qmin)
                begin
                    cnt_next   = 32'hFFFF_FFFF;
                    state_next = ST_OUT;
                end
                else if (avg_reg >= lowered)
                begin
                    cnt_next   = 32'hFFFF_FFFF;
                    verd_next  = VERDICT_FDROP;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    a_next   = (avg_reg - qmin) >> wl_reg;
                    if (cnt_inc == 32'd0)
                    begin
                        state_next = ST_DRAW;
                    end
                    else
                    begin
                        state_next = ST_PROB;
                    end
                end
            end
            ST_PROB:
            begin
                mul_a = a_reg[31:0];
                mul_b = cnt_reg;
                if (a_reg[63:32] != 32'd0)
                begin
                    cnt_next   = 32'd0;
                    verd_next  = VERDICT_PDROP;
                    state_next = ST_DRAW;
                end
                else
                begin
                    state_next = ST_PROB2;
                end
            end
            ST_PROB2:
            begin
                if (mul_p_reg < 64'(tgt_reg))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next   = 32'd0;
                    verd_next  = VERDICT_PDROP;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                mul_a      = base;
                mul_b      = {8'd0, gap};
                state_next = ST_DRAW1;
            end
            ST_DRAW1:
            begin
                dreq.start    = 1'b1;
                dreq.short_op = 1'b1;
                dreq.dividend = {32'd0, maxp};
                dreq.divisor  = {8'd0, gap};
                state_next    = ST_DRAW2;
            end
            ST_DRAW2:
            begin
                if (drsp.done)
                begin
                    per_next   = (drsp.quotient[31:0] == 32'd0) ? 32'd1 : drsp.quotient[31:0];
                    state_next = ST_DRAW3;
                end
            end
            ST_DRAW3:
            begin
                dreq.start    = 1'b1;
                dreq.short_op = 1'b1;
                dreq.dividend = {32'd0, rnd_reg};
                dreq.divisor  = per_reg;
                if (drsp.done)
                begin
                    dreq.start = 1'b0;
                    tgt_next   = drsp.quotient[31:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = {avg_reg, verd_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            avg_reg    <= 64'd0;
            cnt_reg    <= 32'hFFFF_FFFF;
            tgt_reg    <= 32'd0;
            idle_reg   <= 1'b0;
            istart_reg <= 32'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            avg_reg    <= avg_next;
            cnt_reg    <= cnt_next;
            tgt_reg    <= tgt_next;
            idle_reg   <= idle_next;
            istart_reg <= istart_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        blog_reg  <= blog_next;
        now_reg   <= now_next;
        rnd_reg   <= rnd_next;
        mod_reg   <= mod_next;
        tval_reg  <= tval_next;
        itime_reg <= itime_next;
        pen_reg   <= pen_next;
        q_reg     <= q_next;
        a_reg     <= a_next;
        plo_reg   <= plo_next;
        prod_reg  <= prod_next;
        per_reg   <= per_next;
        verd_reg  <= verd_next;
        od_reg    <= od_next;
    end

endmodule
`default_nettype wire
